// ===== rtl/eight_bit_cpu_alu_flags_macros.svh =====
// Assertion macros for the eight-bit CPU ALU block.
// Simulation builds get concurrent assertions; SYNTHESIS builds get empty bodies.
// No dependencies.
`ifndef EIGHT_BIT_CPU_ALU_FLAGS_MACROS_SVH
`define EIGHT_BIT_CPU_ALU_FLAGS_MACROS_SVH

`ifndef SYNTHESIS
// Check an implication on every rising clock edge, held off during reset
`define EBCA_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ebca assertion failed");
// Check that a condition never holds on a rising clock edge, outside reset
`define EBCA_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("ebca forbidden condition seen");
`else
`define EBCA_ASSERT(label, clk, rst_n, prop)
`define EBCA_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ===== rtl/ebca_pkg.sv =====
// Shared types and constants of the eight-bit CPU ALU block.
// Holds the operation codes, flag bit positions and transaction payload structs.
// No dependencies.
package ebca_pkg;

  // Operation codes
  typedef enum logic [3:0] {
    OP_AND   = 4'd0,
    OP_OR    = 4'd1,
    OP_XOR   = 4'd2,
    OP_CP    = 4'd3,
    OP_SUB   = 4'd4,
    OP_INC   = 4'd5,
    OP_DEC   = 4'd6,
    OP_CPL   = 4'd7,
    OP_RL    = 4'd8,
    OP_RLA   = 4'd9,
    OP_RLCA  = 4'd10,
    OP_RRCA  = 4'd11,
    OP_SWAP  = 4'd12,
    OP_BIT   = 4'd13,
    OP_RES   = 4'd14,
    OP_ADD16 = 4'd15
  } op_e;

  // Flag bit positions inside the flag byte
  localparam int unsigned FlagZBit = 7;
  localparam int unsigned FlagNBit = 6;
  localparam int unsigned FlagHBit = 5;
  localparam int unsigned FlagCBit = 4;

  // Input transaction
  typedef struct packed {
    op_e         op;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic [7:0]  flags_in;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [15:0] result;
    logic [7:0]  flags_out;
  } out_t;

endpackage

// ===== rtl/ebca_in_stage.sv =====
// Input register of the eight-bit CPU ALU block.
// Holds one accepted transaction until the result register takes it.
// Depends on ebca_pkg.
module ebca_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  ebca_pkg::in_t data_i,
  output logic          valid_o,
  output ebca_pkg::in_t data_o,
  input  logic          take_i
);

  logic          valid_q, valid_d;
  ebca_pkg::in_t data_q;

  // Accept when empty or when the held transaction moves on this cycle
  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  // Control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, loaded on acceptance
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/ebca_core.sv =====
// Combinational datapath of the eight-bit CPU ALU block.
// Computes the result and new flag byte of one transaction.
// Depends on ebca_pkg.
module ebca_core (
  input  ebca_pkg::in_t  data_i,
  output ebca_pkg::out_t data_o
);

  logic [7:0]  a, b;
  logic [7:0]  r8;
  logic [15:0] res;
  logic        z_kept, c_kept;
  logic        fz, fn, fh, fc;
  logic [8:0]  diff9;
  logic [7:0]  inc8, dec8;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [7:0]  res_mask;

  assign a      = data_i.operand_a[7:0];
  assign b      = data_i.operand_b[7:0];
  assign z_kept = data_i.flags_in[ebca_pkg::FlagZBit];
  assign c_kept = data_i.flags_in[ebca_pkg::FlagCBit];

  // Adders and the RES bit mask
  assign diff9    = {1'b0, a} - {1'b0, b};
  assign inc8     = a + 8'd1;
  assign dec8     = a - 8'd1;
  assign sum17    = {1'b0, data_i.operand_a} + {1'b0, data_i.operand_b};
  assign sum13    = {1'b0, data_i.operand_a[11:0]} + {1'b0, data_i.operand_b[11:0]};
  assign res_mask = ~(8'h01 << data_i.bit_index);

  // Operation select and flag rules
  always_comb begin
    r8  = 8'h00;
    res = 16'h0000;
    fz  = 1'b0;
    fn  = 1'b0;
    fh  = 1'b0;
    fc  = 1'b0;
    unique case (data_i.op) inside
      ebca_pkg::OP_AND: begin
        r8 = a & b;
        fz = (r8 == 8'h00);
        fh = 1'b1;
      end
      ebca_pkg::OP_OR: begin
        r8 = a | b;
        fz = (r8 == 8'h00);
      end
      ebca_pkg::OP_XOR: begin
        r8 = a ^ b;
        fz = (r8 == 8'h00);
      end
      ebca_pkg::OP_CP, ebca_pkg::OP_SUB: begin
        r8 = diff9[7:0];
        fz = (diff9[7:0] == 8'h00);
        fn = 1'b1;
        fh = (a[3:0] < b[3:0]);
        fc = diff9[8];
      end
      ebca_pkg::OP_INC: begin
        r8 = inc8;
        fz = (inc8 == 8'h00);
        fh = (a[3:0] == 4'hF);
        fc = c_kept;
      end
      ebca_pkg::OP_DEC: begin
        r8 = dec8;
        fz = (dec8 == 8'h00);
        fn = 1'b1;
        fh = (a[3:0] == 4'h0);
        fc = c_kept;
      end
      ebca_pkg::OP_CPL: begin
        r8 = ~a;
        fz = z_kept;
        fn = 1'b1;
        fh = 1'b1;
        fc = c_kept;
      end
      ebca_pkg::OP_RL: begin
        r8 = {a[6:0], c_kept};
        fz = (r8 == 8'h00);
        fc = a[7];
      end
      ebca_pkg::OP_RLA: begin
        r8 = {a[6:0], c_kept};
        fc = a[7];
      end
      ebca_pkg::OP_RLCA: begin
        r8 = {a[6:0], a[7]};
        fc = a[7];
      end
      ebca_pkg::OP_RRCA: begin
        r8 = {a[0], a[7:1]};
        fc = a[0];
      end
      ebca_pkg::OP_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        fz = (a == 8'h00);
      end
      ebca_pkg::OP_BIT: begin
        fz = !a[data_i.bit_index];
        fh = 1'b1;
        fc = c_kept;
      end
      ebca_pkg::OP_RES: begin
        r8 = a & res_mask;
        fz = z_kept;
        fn = data_i.flags_in[ebca_pkg::FlagNBit];
        fh = data_i.flags_in[ebca_pkg::FlagHBit];
        fc = c_kept;
      end
      ebca_pkg::OP_ADD16: begin
        fz = z_kept;
        fh = sum13[12];
        fc = sum17[16];
      end
      default: begin
        r8 = 8'h00;
      end
    endcase

    // Compare and bit test hand back the full operand, ADD16 its full sum
    case (data_i.op) inside
      ebca_pkg::OP_CP, ebca_pkg::OP_BIT: res = data_i.operand_a;
      ebca_pkg::OP_ADD16:                res = sum17[15:0];
      default:                           res = {8'h00, r8};
    endcase
  end

  assign data_o.result    = res;
  assign data_o.flags_out = {fz, fn, fh, fc, 4'h0};

endmodule

// ===== rtl/eight_bit_cpu_alu_flags.sv =====
// Top level of the eight-bit CPU ALU block.
// Instantiates ebca_in_stage and ebca_core and holds the result register.
// Depends on ebca_pkg and eight_bit_cpu_alu_flags_macros.svh.
//
// ALU of an 8-bit handheld CPU behind valid/ready channels. Each transaction
// carries an operation code, two operands, a bit index and the old flag byte
// and yields one result transaction: the new operand value and the new flag
// byte (Z N H C in bits 7 to 4, bits 3 to 0 always zero). A transaction waits in
// the input register until the result register can take it, then moves there
// and out_valid_o rises. Both registers advance together, so the block takes
// one transaction per cycle for as long as the output side keeps out_ready_i
// high; the combinational datapath between the two registers sets that figure.
// With the output stalled, the block still takes one more transaction into its
// input register before in_ready_o drops.
`include "eight_bit_cpu_alu_flags_macros.svh"

module eight_bit_cpu_alu_flags (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ebca_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ebca_pkg::out_t out_data_o
);

  logic           s1_valid;
  ebca_pkg::in_t  s1_data;
  ebca_pkg::out_t core_out;
  logic           take;
  logic           out_valid_q, out_valid_d;
  ebca_pkg::out_t out_data_q;

  // Result register can load when empty or being drained
  assign take = !out_valid_q || out_ready_i;

  ebca_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (s1_valid),
    .data_o  (s1_data),
    .take_i  (take)
  );

  ebca_core u_core (
    .data_i (s1_data),
    .data_o (core_out)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = s1_valid;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, loaded when a transaction moves up
  always_ff @(posedge clk_i) begin
    if (take && s1_valid) begin
      out_data_q <= core_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A full, stalled pipeline must refuse new input
  `EBCA_ASSERT_NEVER(a_full_blocks, clk_i, rst_ni, s1_valid && out_valid_q && !out_ready_i && in_ready_o)
  // An accepted transaction lands in the input register
  `EBCA_ASSERT(a_accept_lands, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> s1_valid)
  // A transaction moving up shows the datapath result in the next cycle
  `EBCA_ASSERT(a_result_moves, clk_i, rst_ni, (s1_valid && take) |=> (out_valid_o && out_data_o == $past(core_out)))
  // Low flag nibble stays clear on every delivered result
  `EBCA_ASSERT(a_low_nibble, clk_i, rst_ni, out_valid_o |-> (out_data_o.flags_out[3:0] == 4'h0))

endmodule
